// ===== sv/pip_pkg.sv =====
// shared types for the point-in-polygon test unit
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE,
    S_START,
    S_WAIT,
    S_CMP,
    S_NEXT,
    S_EMIT
  } state_e;

  // which edge the shared datapath is testing
  typedef enum logic {
    EDGE_MAIN,
    EDGE_CLOSE
  } edge_e;

endpackage

`default_nettype wire

// ===== sv/point_in_polygon_test_unit.sv =====
// crossing-number point-in-polygon test with one shared divider
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  vertex  | in_valid_i, in_stall_o, query_x_i, query_y_i,  | in
//          | vertex_x_i, vertex_y_i, last_vertex_i          |
//  result  | out_valid_o, out_stall_i, point_inside_o       | out
//
// a vertex item whose edge straddles the query row runs the edge through the
// restoring divider, one quotient bit per cycle
// a non-straddling edge skips the divider; a first vertex that is not the last is only stored
// a last vertex also tests the closing edge, then hands over the result
// the result register lets the next polygon start while a result waits
// reset clears the sequencer, first-vertex flag, parity and result valid; coordinates are not reset
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_test_unit #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [COORD_WIDTH-1:0] query_x_i,
  input  wire logic [COORD_WIDTH-1:0] query_y_i,
  input  wire logic [COORD_WIDTH-1:0] vertex_x_i,
  input  wire logic [COORD_WIDTH-1:0] vertex_y_i,
  input  wire logic                   last_vertex_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        point_inside_o
);

  localparam int W  = COORD_WIDTH;
  localparam int NW = 2 * W + 2;
  localparam int DW = W + 1;

  pip_pkg::state_e state_q, state_d;
  pip_pkg::edge_e  edge_q;

  logic signed [W-1:0]  px_q, py_q, cur_x_q, cur_y_q;
  logic signed [W-1:0]  first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic                 last_q, seen_q, parity_q;
  logic                 out_valid_q, out_q;
  logic signed [NW-1:0] num_q;
  logic signed [DW-1:0] den_q;
  logic                 q_neg_q;

  logic signed [W-1:0]  xi, yi, xj, yj;
  logic                 straddle;
  logic signed [DW-1:0] dx, dy, den;
  logic signed [NW-1:0] prod;
  logic [NW-1:0]        num_abs;
  logic [DW-1:0]        den_abs;
  logic [NW-1:0]        quo;
  logic                 div_done;
  logic signed [NW:0]   q_s;
  logic signed [NW+1:0] bound;
  logic                 hit;

  logic accept, out_take, emit_fire;
  logic div_start, load_edge, do_cmp, do_next;

  // operand selection for the edge under test
  always_comb begin
    if (edge_q == pip_pkg::EDGE_MAIN) begin
      xi = cur_x_q;
      yi = cur_y_q;
      xj = prev_x_q;
      yj = prev_y_q;
    end else begin
      xi = first_x_q;
      yi = first_y_q;
      xj = cur_x_q;
      yj = cur_y_q;
    end
  end

  always_comb begin
    straddle = (yi > py_q) != (yj > py_q);
    dx       = $signed({xj[W-1], xj}) - $signed({xi[W-1], xi});
    dy       = $signed({py_q[W-1], py_q}) - $signed({yi[W-1], yi});
    den      = $signed({yj[W-1], yj}) - $signed({yi[W-1], yi});
    prod     = dx * dy;
    num_abs  = num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
    den_abs  = den_q[DW-1] ? DW'(-den_q) : DW'(den_q);
    // truncated quotient carries the sign of num/den
    q_s      = q_neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    bound    = $signed({q_s[NW], q_s}) + (NW+2)'(xi);
    hit      = (NW+2)'(px_q) < bound;
  end

  pip_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_abs),
    .divisor_i  (den_abs),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pip_pkg::S_IDLE: begin
        if (in_valid_i && (seen_q || last_vertex_i)) state_d = pip_pkg::S_EDGE;
      end
      pip_pkg::S_EDGE:  state_d = straddle ? pip_pkg::S_START : pip_pkg::S_NEXT;
      pip_pkg::S_START: state_d = pip_pkg::S_WAIT;
      pip_pkg::S_WAIT: begin
        if (div_done) state_d = pip_pkg::S_CMP;
      end
      pip_pkg::S_CMP:   state_d = pip_pkg::S_NEXT;
      pip_pkg::S_NEXT: begin
        if (last_q && edge_q == pip_pkg::EDGE_MAIN) state_d = pip_pkg::S_EDGE;
        else if (last_q)                            state_d = pip_pkg::S_EMIT;
        else                                        state_d = pip_pkg::S_IDLE;
      end
      pip_pkg::S_EMIT: begin
        if (!out_valid_q || !out_stall_i) state_d = pip_pkg::S_IDLE;
      end
      default: state_d = pip_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    load_edge  = 1'b0;
    do_cmp     = 1'b0;
    do_next    = 1'b0;
    emit_fire  = 1'b0;
    unique case (state_q)
      pip_pkg::S_IDLE:  in_stall_o = 1'b0;
      pip_pkg::S_EDGE:  load_edge  = 1'b1;
      pip_pkg::S_START: div_start  = 1'b1;
      pip_pkg::S_WAIT:  ;
      pip_pkg::S_CMP:   do_cmp     = 1'b1;
      pip_pkg::S_NEXT:  do_next    = 1'b1;
      pip_pkg::S_EMIT:  emit_fire  = !out_valid_q || !out_stall_i;
      default:          ;
    endcase
  end

  assign accept   = in_valid_i && !in_stall_o;
  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pip_pkg::S_IDLE;
      edge_q      <= pip_pkg::EDGE_MAIN;
      seen_q      <= 1'b0;
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        seen_q <= 1'b1;
        edge_q <= seen_q ? pip_pkg::EDGE_MAIN : pip_pkg::EDGE_CLOSE;
      end
      if (do_cmp && hit) parity_q <= !parity_q;
      if (do_next) edge_q <= pip_pkg::EDGE_CLOSE;
      if (emit_fire) begin
        seen_q   <= 1'b0;
        parity_q <= 1'b0;
      end
      if (emit_fire)     out_valid_q <= 1'b1;
      else if (out_take) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q    <= query_x_i;
      py_q    <= query_y_i;
      cur_x_q <= vertex_x_i;
      cur_y_q <= vertex_y_i;
      last_q  <= last_vertex_i;
      if (!seen_q) begin
        first_x_q <= vertex_x_i;
        first_y_q <= vertex_y_i;
        prev_x_q  <= vertex_x_i;
        prev_y_q  <= vertex_y_i;
      end
    end
    if (load_edge) begin
      num_q <= prod;
      den_q <= den;
    end
    if (div_start) q_neg_q <= num_q[NW-1] ^ den_q[DW-1];
    if (do_next && edge_q == pip_pkg::EDGE_MAIN) begin
      prev_x_q <= cur_x_q;
      prev_y_q <= cur_y_q;
    end
    if (emit_fire) out_q <= parity_q;
  end

  assign out_valid_o    = out_valid_q;
  assign point_inside_o = out_q;

endmodule

`default_nettype wire

// ===== sv/pip_div.sv =====
// restoring divider on magnitudes, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module pip_div #(
  parameter int NW = 34,
  parameter int DW = 17
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic      [NW-1:0] quotient_o,
  output logic               done_o
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;

  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          fits;

  // shift in the next dividend bit and try the subtraction
  always_comb begin
    rem_sh = {rem_q, quo_q[NW-1]};
    diff   = rem_sh - {1'b0, den_q};
    fits   = (rem_sh >= {1'b0, den_q});
  end

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CW'(NW);
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[NW-2:0], fits};
      rem_q <= fits ? diff[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire

// ===== sv/pip_checker.sv =====
// port-level checks for the point-in-polygon test unit
`timescale 1ns / 1ps
`default_nettype none

module pip_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic last_vertex_i,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic point_inside_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(point_inside_o))
    else $error("stalled result item changed");

  // the closing edge keeps the unit busy after a last vertex
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_vertex_i |=> in_stall_o)
    else $error("input taken right after a last vertex");

  // a new result only appears at the end of a busy stretch
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result item appeared while idle");

endmodule

bind point_in_polygon_test_unit pip_checker u_pip_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .last_vertex_i  (last_vertex_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .point_inside_o (point_inside_o)
);

`default_nettype wire
